// ----- hdl/wsa_pkg.sv -----
// Shared types, register indexes, mode codes and saturation helpers for the window aggregator.
package wsa_pkg;

    localparam int MAX_RESULTS = 8;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_RANGE_START   = 3'd0;
    localparam reg_idx_t REG_RANGE_END     = 3'd1;
    localparam reg_idx_t REG_WINDOW_LENGTH = 3'd2;
    localparam reg_idx_t REG_SLIDE_STEP    = 3'd3;
    localparam reg_idx_t REG_AGG_MODE      = 3'd4;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_SUM   = 3'd0;
    localparam mode_t MODE_AVG   = 3'd1;
    localparam mode_t MODE_MIN   = 3'd2;
    localparam mode_t MODE_MAX   = 3'd3;
    localparam mode_t MODE_COUNT = 3'd4;
    localparam mode_t MODE_RATE  = 3'd5;
    localparam mode_t MODE_DERIV = 3'd6;

    localparam logic signed [47:0] Q_MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q_MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [31:0] sample_value;
        logic               end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        window_start;
        logic signed [47:0] agg_value;
        logic               dropped;
        logic               last_result;
    } out_item_t;

    // One open window: start, running statistics and (time, value) points
    typedef struct packed {
        logic [31:0]        start;
        logic [31:0]        count;
        logic signed [63:0] sum;
        logic signed [31:0] vmin;
        logic signed [31:0] vmax;
        logic [63:0]        first_pt;
        logic [63:0]        prev_pt;
        logic [63:0]        last_pt;
        logic               lost;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_SKIP,
        ST_OPEN,
        ST_ACCUM,
        ST_FLUSH,
        ST_RES,
        ST_DIV,
        ST_DIVEND,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Clip a signed 64-bit value to the signed 48-bit range
    function automatic logic signed [47:0] sat_sum(input logic signed [63:0] x);
        logic signed [47:0] r;
        if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = Q_MAX48;
        end else if (x < 64'shFFFF_8000_0000_0000) begin
            r = Q_MIN48;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clip to the signed 48-bit range
    function automatic logic signed [47:0] sat_quo(input logic [63:0] mag, input logic neg);
        logic signed [47:0] r;
        if (neg) begin
            if (mag > 64'h0000_8000_0000_0000) begin
                r = Q_MIN48;
            end else begin
                r = 48'sd0 - signed'(mag[47:0]);
            end
        end else if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
            r = Q_MAX48;
        end else begin
            r = signed'(mag[47:0]);
        end
        return r;
    endfunction

endpackage

// ----- hdl/windowed_stream_aggregator_core.sv -----
// Top level of the sliding/tumbling time-window aggregator.
//
// Samples (time in seconds, signed Q16.16 value, end-of-stream flag) enter on the
// s_ valid/ready channel; one beat per window result leaves on the m_ channel, in
// window start order, with last_result set on the final result of an input beat.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A small sequencer walks each sample through close, skip, open, accumulate and
// flush steps, accumulating one slot per cycle, and shares a single radix-2
// divider for averages, rates, derivatives and the window skip.
// s_ready is high only while the sequencer is idle; one beat is worked at a time.
// One result is held back until the next is known, so last_result can be marked;
// the output register lets the next result be prepared while the receiver stalls,
// and the sequencer waits when both are full.
// Reset (aresetn low at a clock edge) closes all windows, loads register defaults
// and leaves the output channel empty.
module windowed_stream_aggregator_core #(
    parameter int OPEN_WINDOWS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wsa_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wsa_pkg::out_item_t   m_data,
    input  logic                 cfg_we,
    input  wsa_pkg::reg_idx_t    cfg_index,
    input  logic [31:0]          cfg_wdata
);

    localparam int CW = $clog2(OPEN_WINDOWS + 1);
    localparam int IW = (OPEN_WINDOWS > 1) ? $clog2(OPEN_WINDOWS) : 1;
    localparam logic [CW-1:0] N_FULL = CW'(OPEN_WINDOWS);
    localparam logic [3:0] RES_LIMIT = 4'(wsa_pkg::MAX_RESULTS);

    wsa_pkg::state_t state_reg, state_next;

    logic [31:0]     range_start_reg, range_end_reg, window_length_reg, slide_step_reg;
    wsa_pkg::mode_t  agg_mode_reg;

    logic [31:0]        t_reg;
    logic signed [31:0] v_reg;
    logic               eos_reg;

    wsa_pkg::slot_t  slot_reg [OPEN_WINDOWS];
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   idx_reg;
    logic [3:0]      nres_reg;
    logic            flush_reg;
    logic [32:0]     next_start_reg;
    logic            drop_valid_reg;
    logic [31:0]     drop_time_reg;

    logic [32:0]     div_rem_reg;
    logic [63:0]     div_quo_reg;
    logic [31:0]     div_den_reg;
    logic [5:0]      div_cnt_reg;
    logic            div_neg_reg;
    logic            div_skip_reg;
    logic [32:0]     skip_delta_reg;

    logic signed [47:0]  res_reg;
    wsa_pkg::out_item_t  pend_reg;
    logic                pend_valid_reg;
    wsa_pkg::out_item_t  m_data_reg;
    logic                m_valid_reg;

    logic [31:0]     len_eff, slide_eff;
    logic [IW-1:0]   sel;
    wsa_pkg::slot_t  cur;
    logic            out_free;
    logic            out_load;
    logic            close_hit, skip_hit, open_hit, acc_hit, idx_live;
    logic [33:0]     next_end;
    logic [33:0]     skip_delta;

    // result datapath
    logic signed [47:0] res_direct;
    logic               res_need_div;
    logic [63:0]        rdiv_mag;
    logic [31:0]        rdiv_den;
    logic               rdiv_neg;
    logic [63:0]        pt_a;
    logic [32:0]        vdiff, vdiff_mag;
    logic [63:0]        sum_mag;

    // accumulate datapath
    logic [63:0]        new_pt;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;

    // divider step and skip finish
    logic [32:0]     div_shift;
    logic [33:0]     div_trial;
    logic [31:0]     skip_add;
    logic [34:0]     skip_sum;
    logic [33:0]     open_next;

    assign len_eff   = (window_length_reg == 32'd0) ? 32'd1 : window_length_reg;
    assign slide_eff = (slide_step_reg == 32'd0) ? len_eff : slide_step_reg;
    assign sel       = idx_reg[IW-1:0];
    assign cur       = slot_reg[sel];
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = ((state_reg == wsa_pkg::ST_EMIT) || (state_reg == wsa_pkg::ST_FINISH))
                    && pend_valid_reg && out_free;
    assign idx_live  = idx_reg < n_reg;

    assign close_hit = (n_reg != '0) && (nres_reg < RES_LIMIT)
                    && (({1'b0, slot_reg[0].start} + {1'b0, len_eff}) <= {1'b0, t_reg});
    assign next_end  = {1'b0, next_start_reg} + {2'b0, len_eff};
    assign skip_hit  = (next_start_reg < {1'b0, range_end_reg}) && (next_end <= {2'b0, t_reg});
    assign open_hit  = (next_start_reg < {1'b0, range_end_reg})
                    && (next_start_reg <= {1'b0, t_reg}) && (next_end > {2'b0, t_reg});
    assign acc_hit   = (cur.start <= t_reg)
                    && (({1'b0, cur.start} + {1'b0, len_eff}) > {1'b0, t_reg});
    assign skip_delta = {2'b0, t_reg} + 34'd1 - {2'b0, len_eff} - {1'b0, next_start_reg};

    // Aggregate of the selected slot, or the operands for a division
    always_comb begin
        res_direct   = '0;
        res_need_div = 1'b0;
        rdiv_mag     = '0;
        rdiv_den     = '0;
        rdiv_neg     = 1'b0;
        pt_a         = (agg_mode_reg == wsa_pkg::MODE_RATE) ? cur.first_pt : cur.prev_pt;
        vdiff        = {cur.last_pt[31], cur.last_pt[31:0]} - {pt_a[31], pt_a[31:0]};
        vdiff_mag    = vdiff[32] ? (33'd0 - vdiff) : vdiff;
        sum_mag      = cur.sum[63] ? (64'd0 - cur.sum) : cur.sum;
        unique case (agg_mode_reg)
            wsa_pkg::MODE_SUM: begin
                res_direct = wsa_pkg::sat_sum(cur.sum);
            end
            wsa_pkg::MODE_AVG: begin
                if (cur.count != 32'd0) begin
                    res_need_div = 1'b1;
                    rdiv_mag     = sum_mag;
                    rdiv_den     = cur.count;
                    rdiv_neg     = cur.sum[63];
                end
            end
            wsa_pkg::MODE_MIN: begin
                res_direct = {{16{cur.vmin[31]}}, cur.vmin};
            end
            wsa_pkg::MODE_MAX: begin
                res_direct = {{16{cur.vmax[31]}}, cur.vmax};
            end
            wsa_pkg::MODE_COUNT: begin
                res_direct = cur.count[31] ? wsa_pkg::Q_MAX48 : {1'b0, cur.count[30:0], 16'h0};
            end
            wsa_pkg::MODE_RATE, wsa_pkg::MODE_DERIV: begin
                if ((cur.count >= 32'd2) && (cur.last_pt[63:32] > pt_a[63:32])) begin
                    res_need_div = 1'b1;
                    rdiv_mag     = {31'b0, vdiff_mag};
                    rdiv_den     = cur.last_pt[63:32] - pt_a[63:32];
                    rdiv_neg     = vdiff[32];
                end
            end
            default: begin
                res_direct = '0;
            end
        endcase
    end

    // Saturating add and new point for the selected slot
    always_comb begin
        new_pt   = {t_reg, v_reg};
        sum_wide = {cur.sum[63], cur.sum} + {{33{v_reg[31]}}, v_reg};
        if (sum_wide[64] != sum_wide[63]) begin
            sum_sat = sum_wide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            sum_sat = sum_wide[63:0];
        end
    end

    // Divider step, skip landing and next window start
    always_comb begin
        div_shift = {div_rem_reg[31:0], div_quo_reg[63]};
        div_trial = {1'b0, div_shift} - {2'b0, div_den_reg};
        skip_add  = (div_rem_reg[31:0] != 32'd0) ? (slide_eff - div_rem_reg[31:0]) : 32'd0;
        skip_sum  = {2'b0, next_start_reg} + {2'b0, skip_delta_reg} + {3'b0, skip_add};
        open_next = {1'b0, next_start_reg} + {2'b0, slide_eff};
    end

    // Hold the state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one beat through its steps
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            wsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = wsa_pkg::ST_CLOSE;
                end
            end
            wsa_pkg::ST_CLOSE: begin
                state_next = close_hit ? wsa_pkg::ST_RES : wsa_pkg::ST_SKIP;
            end
            wsa_pkg::ST_SKIP: begin
                state_next = skip_hit ? wsa_pkg::ST_DIV : wsa_pkg::ST_OPEN;
            end
            wsa_pkg::ST_OPEN: begin
                if (!open_hit || (n_reg >= N_FULL)) begin
                    state_next = wsa_pkg::ST_ACCUM;
                end
            end
            wsa_pkg::ST_ACCUM: begin
                if (!idx_live) begin
                    state_next = eos_reg ? wsa_pkg::ST_FLUSH : wsa_pkg::ST_FINISH;
                end
            end
            wsa_pkg::ST_FLUSH: begin
                state_next = (idx_live && (nres_reg < RES_LIMIT)) ? wsa_pkg::ST_RES
                                                                 : wsa_pkg::ST_FINISH;
            end
            wsa_pkg::ST_RES: begin
                state_next = res_need_div ? wsa_pkg::ST_DIV : wsa_pkg::ST_EMIT;
            end
            wsa_pkg::ST_DIV: begin
                if (div_cnt_reg == 6'd63) begin
                    state_next = wsa_pkg::ST_DIVEND;
                end
            end
            wsa_pkg::ST_DIVEND: begin
                state_next = div_skip_reg ? wsa_pkg::ST_OPEN : wsa_pkg::ST_EMIT;
            end
            wsa_pkg::ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = flush_reg ? wsa_pkg::ST_FLUSH : wsa_pkg::ST_CLOSE;
                end
            end
            wsa_pkg::ST_FINISH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = wsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Slot storage: open, accumulate and shift out closed windows
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            wsa_pkg::ST_OPEN: begin
                if (open_hit && (n_reg < N_FULL)) begin
                    slot_reg[n_reg[IW-1:0]] <= '{
                        start:    next_start_reg[31:0],
                        count:    32'd0,
                        sum:      64'sd0,
                        vmin:     32'sd0,
                        vmax:     32'sd0,
                        first_pt: 64'd0,
                        prev_pt:  64'd0,
                        last_pt:  64'd0,
                        lost:     drop_valid_reg && (next_start_reg <= {1'b0, drop_time_reg})
                    };
                end
            end
            wsa_pkg::ST_ACCUM: begin
                if (idx_live && acc_hit) begin
                    slot_reg[sel].sum     <= sum_sat;
                    slot_reg[sel].last_pt <= new_pt;
                    if (cur.count != 32'hFFFF_FFFF) begin
                        slot_reg[sel].count <= cur.count + 32'd1;
                    end
                    if (cur.count == 32'd0) begin
                        slot_reg[sel].vmin     <= v_reg;
                        slot_reg[sel].vmax     <= v_reg;
                        slot_reg[sel].first_pt <= new_pt;
                        slot_reg[sel].prev_pt  <= new_pt;
                    end else begin
                        if (v_reg < cur.vmin) begin
                            slot_reg[sel].vmin <= v_reg;
                        end
                        if (v_reg > cur.vmax) begin
                            slot_reg[sel].vmax <= v_reg;
                        end
                        slot_reg[sel].prev_pt <= cur.last_pt;
                    end
                end
            end
            wsa_pkg::ST_EMIT: begin
                if ((!pend_valid_reg || out_free) && !flush_reg) begin
                    for (int i = 0; i < OPEN_WINDOWS - 1; i++) begin
                        slot_reg[i] <= slot_reg[i + 1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control, divider and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg   <= 32'd0;
            range_end_reg     <= 32'd3600;
            window_length_reg <= 32'd60;
            slide_step_reg    <= 32'd0;
            agg_mode_reg      <= wsa_pkg::MODE_SUM;
            n_reg             <= '0;
            idx_reg           <= '0;
            nres_reg          <= '0;
            flush_reg         <= 1'b0;
            next_start_reg    <= 33'd0;
            drop_valid_reg    <= 1'b0;
            drop_time_reg     <= 32'd0;
            div_cnt_reg       <= '0;
            div_skip_reg      <= 1'b0;
            pend_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // load a result beat, or drop the one just taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                wsa_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        t_reg     <= s_data.sample_time;
                        v_reg     <= s_data.sample_value;
                        eos_reg   <= s_data.end_of_stream;
                        idx_reg   <= '0;
                        nres_reg  <= '0;
                        flush_reg <= 1'b0;
                    end
                end
                wsa_pkg::ST_CLOSE: begin
                    idx_reg <= '0;
                end
                wsa_pkg::ST_SKIP: begin
                    // load the divider with the distance to the first live window
                    if (skip_hit) begin
                        div_rem_reg    <= '0;
                        div_quo_reg    <= {31'b0, skip_delta[32:0]};
                        div_den_reg    <= slide_eff;
                        div_neg_reg    <= 1'b0;
                        div_skip_reg   <= 1'b1;
                        div_cnt_reg    <= '0;
                        skip_delta_reg <= skip_delta[32:0];
                    end
                end
                wsa_pkg::ST_OPEN: begin
                    if (open_hit) begin
                        if (n_reg >= N_FULL) begin
                            if (!drop_valid_reg || (t_reg > drop_time_reg)) begin
                                drop_time_reg <= t_reg;
                            end
                            drop_valid_reg <= 1'b1;
                        end else begin
                            n_reg          <= n_reg + 1'b1;
                            next_start_reg <= (open_next > {2'b0, range_end_reg})
                                            ? {1'b0, range_end_reg} : open_next[32:0];
                        end
                    end
                    if (!open_hit || (n_reg >= N_FULL)) begin
                        idx_reg <= '0;
                    end
                end
                wsa_pkg::ST_ACCUM: begin
                    if (idx_live) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        idx_reg   <= '0;
                        flush_reg <= eos_reg;
                    end
                end
                wsa_pkg::ST_FLUSH: begin
                    // reset the stream once every open window is reported or the result limit is reached
                    if (!(idx_live && (nres_reg < RES_LIMIT))) begin
                        n_reg          <= '0;
                        next_start_reg <= {1'b0, range_start_reg};
                        drop_valid_reg <= 1'b0;
                        drop_time_reg  <= 32'd0;
                    end
                end
                wsa_pkg::ST_RES: begin
                    res_reg <= res_direct;
                    if (res_need_div) begin
                        div_rem_reg  <= '0;
                        div_quo_reg  <= rdiv_mag;
                        div_den_reg  <= rdiv_den;
                        div_neg_reg  <= rdiv_neg;
                        div_skip_reg <= 1'b0;
                        div_cnt_reg  <= '0;
                    end
                end
                wsa_pkg::ST_DIV: begin
                    // one restoring quotient bit per cycle
                    if (!div_trial[33]) begin
                        div_rem_reg <= div_trial[32:0];
                        div_quo_reg <= {div_quo_reg[62:0], 1'b1};
                    end else begin
                        div_rem_reg <= div_shift;
                        div_quo_reg <= {div_quo_reg[62:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                end
                wsa_pkg::ST_DIVEND: begin
                    if (div_skip_reg) begin
                        next_start_reg <= (skip_sum > {3'b0, range_end_reg})
                                        ? {1'b0, range_end_reg} : skip_sum[32:0];
                    end else begin
                        res_reg <= wsa_pkg::sat_quo(div_quo_reg, div_neg_reg);
                    end
                end
                wsa_pkg::ST_EMIT: begin
                    // advance the held result and hold the new one
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_data_reg <= pend_reg;
                        end
                        pend_reg <= '{
                            window_start: cur.start,
                            agg_value:    res_reg,
                            dropped:      cur.lost,
                            last_result:  1'b0
                        };
                        pend_valid_reg <= 1'b1;
                        nres_reg       <= nres_reg + 4'd1;
                        if (flush_reg) begin
                            idx_reg <= idx_reg + 1'b1;
                        end else begin
                            n_reg <= n_reg - 1'b1;
                        end
                    end
                end
                wsa_pkg::ST_FINISH: begin
                    if (pend_valid_reg && out_free) begin
                        m_data_reg <= '{
                            window_start: pend_reg.window_start,
                            agg_value:    pend_reg.agg_value,
                            dropped:      pend_reg.dropped,
                            last_result:  1'b1
                        };
                        pend_valid_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // register writes; the user must make them only while idle, the block does not check
            if (cfg_we) begin
                unique case (cfg_index)
                    wsa_pkg::REG_RANGE_START: begin
                        range_start_reg <= cfg_wdata;
                        next_start_reg  <= {1'b0, cfg_wdata};
                    end
                    wsa_pkg::REG_RANGE_END:     range_end_reg     <= cfg_wdata;
                    wsa_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                    wsa_pkg::REG_SLIDE_STEP:    slide_step_reg    <= cfg_wdata;
                    wsa_pkg::REG_AGG_MODE:      agg_mode_reg      <= cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/wsa_checker.sv -----
// Port-level checks for the window aggregator and their bind to the top level.
module wsa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input wsa_pkg::out_item_t m_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The block is ready right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("not ready after reset");

    // The block drops s_ready after accepting a sample
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again right after a sample beat");

    // Only the last result of a sample may still wait when the block is idle
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_data.last_result)
        else $error("idle with a non-final result waiting");

endmodule

bind windowed_stream_aggregator_core wsa_checker u_wsa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
